// ===== sv/srv_pkg.sv =====
// ----------------------------------------------------------------------------
// Schroeder reverb package
// Shared types and constants for the reverb datapath.
// ----------------------------------------------------------------------------
package srv_pkg;

  localparam int unsigned LEN_CA = 1426;
  localparam int unsigned LEN_CB = 1781;
  localparam int unsigned LEN_CC = 1973;
  localparam int unsigned LEN_CD = 2098;
  localparam int unsigned LEN_AA = 240;
  localparam int unsigned LEN_AB = 82;

  localparam logic [15:0] GAIN_CA = 16'd50463;
  localparam logic [15:0] GAIN_CB = 16'd52429;
  localparam logic [15:0] GAIN_CC = 16'd55050;
  localparam logic [15:0] GAIN_CD = 16'd57672;

  localparam logic [16:0] MIX_WET_RST   = 17'd13107;
  localparam logic [15:0] ROOM_RST      = 16'd45875;
  localparam logic [15:0] DAMPING_RST   = 16'd19661;
  localparam logic [12:0] PREDELAY_RST  = 13'd960;

  localparam logic [2:0] REG_MIX_WET   = 3'd0;
  localparam logic [2:0] REG_ROOM      = 3'd1;
  localparam logic [2:0] REG_DAMPING   = 3'd2;
  localparam logic [2:0] REG_PREDELAY  = 3'd3;
  localparam logic [2:0] REG_REVERB_ON = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE, ST_PD_RD, ST_PD_WAIT,
    ST_CB_RD, ST_CB_WAIT, ST_CB_Z, ST_CB_F, ST_CB_WR,
    ST_SUM,
    ST_AP_RD, ST_AP_WAIT, ST_AP_WR,
    ST_MIX_A, ST_MIX_B, ST_OUT,
    ST_CLEAR
  } srv_state_t;

  typedef struct packed {
    logic        bypass;
    logic [23:0] sample;
  } srv_res_t;

  typedef struct packed {
    logic        bypass;
    logic [7:0]  chan;
    logic [23:0] sample;
  } srv_job_t;

  function automatic logic signed [23:0] sat24(input logic signed [49:0] v);
    if (v > 50'sd8388607) return 24'sh7FFFFF;
    else if (v < -50'sd8388608) return 24'sh800000;
    else return v[23:0];
  endfunction

endpackage

// ===== sv/srv_ram.sv =====
// ----------------------------------------------------------------------------
// Reverb generic RAM
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module srv_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== sv/srv_front.sv =====
// ----------------------------------------------------------------------------
// Reverb front end
// Accepts requests, classifies them as bypass or reverb, and queues them.
// ----------------------------------------------------------------------------
module srv_front
  import srv_pkg::*;
#(
  parameter int unsigned CHANNELS = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     reverb_on,
  input  logic     in_push,
  output logic     in_full,
  input  logic     in_channel,
  input  logic [23:0] in_sample_in,
  output logic     job_valid,
  output srv_job_t job,
  input  logic     job_take
);

  srv_job_t q_r [2];
  logic     wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic     push_ok;
  srv_job_t new_job;

  assign in_full   = cnt_r[1];
  assign push_ok   = in_push && !in_full;
  assign job_valid = cnt_r != 2'd0;
  assign job       = q_r[rp_r];

  always_comb begin
    new_job.chan   = 8'(in_channel);
    new_job.sample = in_sample_in;
    new_job.bypass = !reverb_on || (32'(in_channel) >= CHANNELS);
    wp_nxt  = wp_r ^ push_ok;
    rp_nxt  = rp_r ^ (job_take && job_valid);
    cnt_nxt = cnt_r + 2'(push_ok) - 2'(job_take && job_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push_ok) begin
      q_r[wp_r] <= new_job;
    end
  end

endmodule

// ===== sv/srv_back.sv =====
// ----------------------------------------------------------------------------
// Reverb back end
// Runs pre-delay, combs, allpasses and the mix, with one multiplier shared by the combs and mix.
// ----------------------------------------------------------------------------
module srv_back
  import srv_pkg::*;
#(
  parameter int unsigned CHANNELS         = 2,
  parameter int unsigned MAX_PREDELAY_LEN = 4800
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        clear_req,
  input  logic [16:0] mix_wet,
  input  logic [15:0] room_scale,
  input  logic [15:0] damping,
  input  logic [12:0] predelay_length,
  input  logic        job_valid,
  input  srv_job_t    job,
  output logic        job_take,
  input  logic        res_full,
  output logic        res_push,
  output logic [23:0] res_sample
);

  localparam int unsigned CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned PDD = CHANNELS * MAX_PREDELAY_LEN;
  localparam int unsigned AAD = CHANNELS * LEN_AA;
  localparam int unsigned ABD = CHANNELS * LEN_AB;
  localparam int unsigned CAD = CHANNELS * LEN_CA;
  localparam int unsigned CBD = CHANNELS * LEN_CB;
  localparam int unsigned CCD = CHANNELS * LEN_CC;
  localparam int unsigned CDD = CHANNELS * LEN_CD;
  localparam int unsigned PDW = $clog2(PDD);
  localparam int unsigned AAW = $clog2(AAD);
  localparam int unsigned ABW = $clog2(ABD);
  localparam int unsigned CAW = $clog2(CAD);
  localparam int unsigned CBW = $clog2(CBD);
  localparam int unsigned CCW = $clog2(CCD);
  localparam int unsigned CDW = $clog2(CDD);
  localparam int unsigned MXD = (CDD > PDD) ? CDD : PDD;
  localparam int unsigned CLW = $clog2(MXD + 1);
  localparam int unsigned PPW = $clog2(MAX_PREDELAY_LEN + 1);

  srv_state_t st_r, st_nxt;
  logic [CW-1:0]  ch_r;
  logic signed [23:0] x_r, d_r, y_r, s_r;
  logic        byp_r;
  logic signed [25:0] sum_r;
  logic signed [49:0] acc_r;
  logic [1:0]  k_r;
  logic        ak_r;
  logic [CLW-1:0] clr_r;
  logic [PPW-1:0] pd_pos_r [CHANNELS];
  logic [11:0]    cb_pos_r [CHANNELS][4];
  logic [7:0]     ap_pos_r [CHANNELS][2];
  logic [15:0]    fb_r [4];

  logic signed [24:0] ma;
  logic signed [17:0] mb;
  logic signed [49:0] mp;
  logic signed [24:0] wr_val;

  logic [PDW-1:0] pd_a; logic pd_we; logic [23:0] pd_q;
  logic [CAW-1:0] ca_a; logic ca_we; logic [23:0] ca_q;
  logic [CBW-1:0] cb_a; logic cb_we; logic [23:0] cb_q;
  logic [CCW-1:0] cc_a; logic cc_we; logic [23:0] cc_q;
  logic [CDW-1:0] cd_a; logic cd_we; logic [23:0] cd_q;
  logic [AAW-1:0] aa_a; logic aa_we; logic [23:0] aa_q;
  logic [ABW-1:0] ab_a; logic ab_we; logic [23:0] ab_q;
  logic [23:0] wdata;
  logic clearing;
  logic signed [23:0] cq, aq;
  logic [11:0] cpos, clen;
  logic [7:0]  apos, alen;
  logic [PPW-1:0] ppos;
  logic signed [23:0] apv;

  // Comb feedback gains are recomputed whenever the room scale changes.
  always_ff @(posedge clk) begin
    fb_r[0] <= 16'((32'(GAIN_CA) * 32'(room_scale) + 32'h8000) >> 16);
    fb_r[1] <= 16'((32'(GAIN_CB) * 32'(room_scale) + 32'h8000) >> 16);
    fb_r[2] <= 16'((32'(GAIN_CC) * 32'(room_scale) + 32'h8000) >> 16);
    fb_r[3] <= 16'((32'(GAIN_CD) * 32'(room_scale) + 32'h8000) >> 16);
  end

  assign clearing = (st_r == ST_CLEAR);
  assign mp = 50'(ma) * 50'(mb);

  always_comb begin
    unique case (k_r)
      2'd0: begin cq = ca_q; clen = 12'(LEN_CA); end
      2'd1: begin cq = cb_q; clen = 12'(LEN_CB); end
      2'd2: begin cq = cc_q; clen = 12'(LEN_CC); end
      default: begin cq = cd_q; clen = 12'(LEN_CD); end
    endcase
    cpos = cb_pos_r[ch_r][k_r];
    if (cpos >= clen) cpos = '0;
    aq   = ak_r ? ab_q : aa_q;
    alen = ak_r ? 8'(LEN_AB) : 8'(LEN_AA);
    apos = ap_pos_r[ch_r][ak_r];
    if (apos >= alen) apos = '0;
    ppos = pd_pos_r[ch_r];
    if ((32'(ppos) >= 32'(predelay_length)) || (32'(ppos) >= MAX_PREDELAY_LEN)) ppos = '0;
  end

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (st_r)
      ST_CB_Z: begin ma = 25'(y_r); mb = 18'(17'h10000 - 17'(damping)); end
      ST_CB_F: begin ma = 25'(acc_r); mb = 18'(fb_r[k_r]); end
      ST_MIX_A: begin ma = 25'(x_r); mb = 18'h10000 - 18'(mix_wet); end
      ST_MIX_B: begin ma = 25'(s_r); mb = 18'(mix_wet); end
      default: ;
    endcase
  end

  always_comb begin
    wr_val = 25'(d_r) + 25'((acc_r + 50'sh8000) >>> 16);
    apv = sat24(50'(s_r) - ((50'(aq) + 50'sd1) >>> 1));
  end

  always_comb begin
    st_nxt = st_r;
    if (clear_req) begin
      st_nxt = ST_CLEAR;
    end else begin
      unique case (st_r)
        ST_IDLE: if (job_valid && !res_full) begin
          st_nxt = job.bypass ? ST_OUT : ST_PD_RD;
        end
        ST_PD_RD: st_nxt = ST_PD_WAIT;
        ST_PD_WAIT: st_nxt = ST_CB_RD;
        ST_CB_RD: st_nxt = ST_CB_WAIT;
        ST_CB_WAIT: st_nxt = ST_CB_Z;
        ST_CB_Z: st_nxt = ST_CB_F;
        ST_CB_F: st_nxt = ST_CB_WR;
        ST_CB_WR: st_nxt = (k_r == 2'd3) ? ST_SUM : ST_CB_RD;
        ST_SUM: st_nxt = ST_AP_RD;
        ST_AP_RD: st_nxt = ST_AP_WAIT;
        ST_AP_WAIT: st_nxt = ST_AP_WR;
        ST_AP_WR: st_nxt = ak_r ? ST_MIX_A : ST_AP_RD;
        ST_MIX_A: st_nxt = ST_MIX_B;
        ST_MIX_B: st_nxt = ST_OUT;
        ST_OUT: st_nxt = ST_IDLE;
        ST_CLEAR: st_nxt = (32'(clr_r) == MXD - 1) ? ST_IDLE : ST_CLEAR;
        default: st_nxt = ST_IDLE;
      endcase
    end
  end

  always_comb begin
    job_take = (st_r == ST_IDLE) && job_valid && !res_full && !clear_req;
    res_push = (st_r == ST_OUT);
    res_sample = byp_r ? x_r : s_r;
    pd_we = 1'b0; ca_we = 1'b0; cb_we = 1'b0; cc_we = 1'b0; cd_we = 1'b0;
    aa_we = 1'b0; ab_we = 1'b0;
    wdata = '0;
    pd_a = PDW'(32'(ch_r) * MAX_PREDELAY_LEN + 32'(ppos));
    ca_a = CAW'(32'(ch_r) * LEN_CA + 32'(cpos));
    cb_a = CBW'(32'(ch_r) * LEN_CB + 32'(cpos));
    cc_a = CCW'(32'(ch_r) * LEN_CC + 32'(cpos));
    cd_a = CDW'(32'(ch_r) * LEN_CD + 32'(cpos));
    aa_a = AAW'(32'(ch_r) * LEN_AA + 32'(apos));
    ab_a = ABW'(32'(ch_r) * LEN_AB + 32'(apos));
    if (clearing) begin
      pd_a = PDW'(clr_r); ca_a = CAW'(clr_r); cb_a = CBW'(clr_r);
      cc_a = CCW'(clr_r); cd_a = CDW'(clr_r); aa_a = AAW'(clr_r);
      ab_a = ABW'(clr_r);
      pd_we = 32'(clr_r) < PDD; ca_we = 32'(clr_r) < CAD;
      cb_we = 32'(clr_r) < CBD; cc_we = 32'(clr_r) < CCD;
      cd_we = 32'(clr_r) < CDD; aa_we = 32'(clr_r) < AAD;
      ab_we = 32'(clr_r) < ABD;
    end else if (st_r == ST_PD_WAIT) begin
      pd_we = 1'b1;
      wdata = x_r;
    end else if (st_r == ST_CB_WR) begin
      wdata = sat24(50'(wr_val));
      ca_we = (k_r == 2'd0); cb_we = (k_r == 2'd1);
      cc_we = (k_r == 2'd2); cd_we = (k_r == 2'd3);
    end else if (st_r == ST_AP_WR) begin
      wdata = apv;
      aa_we = !ak_r; ab_we = ak_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_CLEAR;
      clr_r <= '0;
      k_r   <= '0;
      ak_r  <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        pd_pos_r[c] <= '0;
        for (int k = 0; k < 4; k++) cb_pos_r[c][k] <= '0;
        for (int k = 0; k < 2; k++) ap_pos_r[c][k] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (clear_req) begin
        clr_r <= '0;
        for (int c = 0; c < CHANNELS; c++) begin
          pd_pos_r[c] <= '0;
          for (int k = 0; k < 4; k++) cb_pos_r[c][k] <= '0;
          for (int k = 0; k < 2; k++) ap_pos_r[c][k] <= '0;
        end
      end else begin
        if (clearing) clr_r <= clr_r + 1'b1;
        unique case (st_r)
          ST_PD_WAIT: begin
            pd_pos_r[ch_r] <= (32'(ppos) + 1 >= 32'(predelay_length)) ? '0 : ppos + 1'b1;
            k_r <= '0;
          end
          ST_CB_WR: begin
            cb_pos_r[ch_r][k_r] <= (cpos + 12'd1 >= clen) ? '0 : cpos + 12'd1;
            k_r <= k_r + 2'd1;
          end
          ST_SUM: ak_r <= 1'b0;
          ST_AP_WR: begin
            ap_pos_r[ch_r][ak_r] <= (apos + 8'd1 >= alen) ? '0 : apos + 8'd1;
            ak_r <= !ak_r;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      ST_IDLE: begin
        x_r   <= job.sample;
        byp_r <= job.bypass;
        ch_r  <= CW'(job.chan);
        sum_r <= '0;
      end
      ST_PD_WAIT: d_r <= pd_q;
      ST_CB_WAIT: begin
        y_r   <= cq;
        sum_r <= sum_r + 26'(cq);
      end
      ST_CB_Z: acc_r <= (mp + 50'sh8000) >>> 16;
      ST_CB_F: acc_r <= mp;
      ST_SUM: s_r <= 24'((sum_r + 26'sd2) >>> 2);
      ST_AP_WR: s_r <= sat24(50'(aq) + ((50'(apv) + 50'sd1) >>> 1));
      ST_MIX_A: acc_r <= mp;
      ST_MIX_B: s_r <= sat24((acc_r + mp + 50'sh8000) >>> 16);
      default: ;
    endcase
  end

  srv_ram #(.WIDTH(24), .DEPTH(PDD)) u_pd (.clk, .we(pd_we), .addr(pd_a), .wdata, .rdata(pd_q));
  srv_ram #(.WIDTH(24), .DEPTH(CAD)) u_ca (.clk, .we(ca_we), .addr(ca_a), .wdata, .rdata(ca_q));
  srv_ram #(.WIDTH(24), .DEPTH(CBD)) u_cb (.clk, .we(cb_we), .addr(cb_a), .wdata, .rdata(cb_q));
  srv_ram #(.WIDTH(24), .DEPTH(CCD)) u_cc (.clk, .we(cc_we), .addr(cc_a), .wdata, .rdata(cc_q));
  srv_ram #(.WIDTH(24), .DEPTH(CDD)) u_cd (.clk, .we(cd_we), .addr(cd_a), .wdata, .rdata(cd_q));
  srv_ram #(.WIDTH(24), .DEPTH(AAD)) u_aa (.clk, .we(aa_we), .addr(aa_a), .wdata, .rdata(aa_q));
  srv_ram #(.WIDTH(24), .DEPTH(ABD)) u_ab (.clk, .we(ab_we), .addr(ab_a), .wdata, .rdata(ab_q));

endmodule

// ===== sv/srv_outq.sv =====
// ----------------------------------------------------------------------------
// Reverb result queue
// Two-entry queue that holds finished results for the output side.
// ----------------------------------------------------------------------------
module srv_outq (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic [23:0] din,
  output logic        full,
  output logic        empty,
  input  logic        pop,
  output logic [23:0] dout
);

  logic [23:0] q_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic do_pop;

  assign full   = cnt_r[1];
  assign empty  = cnt_r == 2'd0;
  assign do_pop = pop && !empty;
  assign dout   = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_r ^ push;
      rp_r  <= rp_r ^ do_pop;
      cnt_r <= cnt_r + 2'(push) - 2'(do_pop);
    end
    if (push) q_r[wp_r] <= din;
  end

endmodule

// ===== sv/schroeder_reverb_unit.sv =====
// ----------------------------------------------------------------------------
// Schroeder reverb unit
// A reverb sample runs through the sequence (pre-delay, four combs, sum, two
// allpasses, mix), and the next sample is taken only after its result is pushed;
// a bypassed sample goes straight to the result, and samples wait while the
// result queue is full.
// After reset and after every write to a defined register, a clearing pass over
// every delay-line address runs before items are taken.
// ----------------------------------------------------------------------------
module schroeder_reverb_unit
  import srv_pkg::*;
#(
  parameter int unsigned CHANNELS         = 2,
  parameter int unsigned MAX_PREDELAY_LEN = 4800
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_channel,
  input  logic signed [23:0] in_sample_in,
  output logic        out_empty,
  input  logic        out_pop,
  output logic signed [23:0] out_sample_out,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [16:0] mix_wet_r;
  logic [15:0] room_scale_r, damping_r;
  logic [12:0] predelay_r;
  logic        reverb_on_r;
  logic        wr, clear_req, job_valid, job_take, res_full, res_push;
  logic        front_full;
  logic [2:0]  idx;
  srv_job_t    job;
  logic [23:0] res_sample, out_q;
  logic [16:0] mw;
  logic [15:0] rs, dp;
  logic [12:0] pl;

  assign cfg_pready = 1'b1;
  assign idx = cfg_paddr[4:2];
  assign wr  = cfg_psel && cfg_penable && cfg_pwrite;
  assign clear_req = wr && (idx <= REG_REVERB_ON);
  assign in_full = front_full;
  assign out_sample_out = out_q;

  always_comb begin
    mw = cfg_pwdata[16:0];
    if (mw > 17'd65536) mw = 17'd65536;
    rs = cfg_pwdata[15:0];
    if (rs < 16'd13107) rs = 16'd13107;
    if (rs > 16'd62259) rs = 16'd62259;
    dp = cfg_pwdata[15:0];
    if (dp > 16'd45875) dp = 16'd45875;
    pl = cfg_pwdata[12:0];
    if (pl == 13'd0) pl = 13'd1;
    if (32'(pl) > MAX_PREDELAY_LEN) pl = 13'(MAX_PREDELAY_LEN);
    unique case (idx)
      REG_MIX_WET:   cfg_prdata = 32'(mix_wet_r);
      REG_ROOM:      cfg_prdata = 32'(room_scale_r);
      REG_DAMPING:   cfg_prdata = 32'(damping_r);
      REG_PREDELAY:  cfg_prdata = 32'(predelay_r);
      REG_REVERB_ON: cfg_prdata = 32'(reverb_on_r);
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_wet_r    <= MIX_WET_RST;
      room_scale_r <= ROOM_RST;
      damping_r    <= DAMPING_RST;
      predelay_r   <= PREDELAY_RST;
      reverb_on_r  <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        REG_MIX_WET:   mix_wet_r    <= mw;
        REG_ROOM:      room_scale_r <= rs;
        REG_DAMPING:   damping_r    <= dp;
        REG_PREDELAY:  predelay_r   <= pl;
        REG_REVERB_ON: reverb_on_r  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  srv_front #(.CHANNELS(CHANNELS)) u_front (
    .clk, .rst_n, .reverb_on(reverb_on_r), .in_push, .in_full(front_full),
    .in_channel, .in_sample_in, .job_valid, .job, .job_take
  );

  srv_back #(.CHANNELS(CHANNELS), .MAX_PREDELAY_LEN(MAX_PREDELAY_LEN)) u_back (
    .clk, .rst_n, .clear_req, .mix_wet(mix_wet_r), .room_scale(room_scale_r),
    .damping(damping_r), .predelay_length(predelay_r), .job_valid, .job,
    .job_take, .res_full, .res_push, .res_sample
  );

  srv_outq u_outq (
    .clk, .rst_n, .push(res_push), .din(res_sample), .full(res_full),
    .empty(out_empty), .pop(out_pop), .dout(out_q)
  );

endmodule

// ===== bench/schroeder_reverb_checker.sv =====
// ----------------------------------------------------------------------------
// Schroeder reverb checker
// Watches the request and result queues and the register port, keeps its own
// per-channel reverb state, and compares every popped result with the oldest
// predicted sample.
// ----------------------------------------------------------------------------
module schroeder_reverb_checker
  import srv_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic               in_full,
  input  logic               in_channel,
  input  logic signed [23:0] in_sample_in,
  input  logic               out_empty,
  input  logic               out_pop,
  input  logic signed [23:0] out_sample_out,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  input  logic               cfg_pready,
  output int                 fail_count,
  output int                 pending,
  output int                 results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PD_MAX = 4800;

  logic [16:0] wet_share;
  logic [15:0] room;
  logic [15:0] damp;
  logic [12:0] pd_len;
  logic        enabled;

  logic signed [23:0] pd_mem [2][PD_MAX];
  logic signed [23:0] comb_mem [2][4][2098];
  logic signed [23:0] ap_mem [2][2][240];
  int pd_idx [2];
  int comb_idx [2][4];
  int ap_idx [2][2];

  logic signed [23:0] expected_samples [$];
  int comb_len_tab [4] = '{LEN_CA, LEN_CB, LEN_CC, LEN_CD};
  int ap_len_tab [2] = '{LEN_AA, LEN_AB};
  longint comb_gain_tab [4] = '{longint'(GAIN_CA), longint'(GAIN_CB),
                                longint'(GAIN_CC), longint'(GAIN_CD)};

  function automatic longint round_shift(longint p, int sh);
    return (p + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic logic signed [23:0] clip24(longint v);
    if (v > 8388607) return 24'sh7FFFFF;
    if (v < -8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  task automatic clear_reverb_state();
    for (int c = 0; c < 2; c++) begin
      for (int i = 0; i < PD_MAX; i++) pd_mem[c][i] = '0;
      for (int k = 0; k < 4; k++) begin
        for (int i = 0; i < 2098; i++) comb_mem[c][k][i] = '0;
        comb_idx[c][k] = 0;
      end
      for (int k = 0; k < 2; k++) begin
        for (int i = 0; i < 240; i++) ap_mem[c][k][i] = '0;
        ap_idx[c][k] = 0;
      end
      pd_idx[c] = 0;
    end
  endtask

  task automatic apply_register(logic [2:0] idx, logic [31:0] val);
    logic [31:0] v;
    case (idx)
      REG_MIX_WET: begin
        v = val & 32'h1FFFF;
        wet_share = (v > 65536) ? 17'd65536 : v[16:0];
      end
      REG_ROOM: begin
        v = val & 32'hFFFF;
        if (v < 13107) v = 13107;
        if (v > 62259) v = 62259;
        room = v[15:0];
      end
      REG_DAMPING: begin
        v = val & 32'hFFFF;
        damp = (v > 45875) ? 16'd45875 : v[15:0];
      end
      REG_PREDELAY: begin
        v = val & 32'h1FFF;
        if (v < 1) v = 1;
        if (v > PD_MAX) v = PD_MAX;
        pd_len = v[12:0];
      end
      REG_REVERB_ON: enabled = val[0];
      default: return;
    endcase
    clear_reverb_state();
  endtask

  function automatic logic signed [23:0] reverb_sample(int c, logic signed [23:0] x);
    int p;
    longint d, sum, y, z, fb, s, v, mixed;
    if (!enabled) return x;
    p = pd_idx[c];
    if (p >= pd_len) p = 0;
    d = pd_mem[c][p];
    pd_mem[c][p] = x;
    pd_idx[c] = (p + 1 >= pd_len) ? 0 : p + 1;
    sum = 0;
    for (int k = 0; k < 4; k++) begin
      p = comb_idx[c][k];
      fb = round_shift(comb_gain_tab[k] * longint'(room), 16);
      y = comb_mem[c][k][p];
      z = round_shift(y * (65536 - longint'(damp)), 16);
      comb_mem[c][k][p] = clip24(d + round_shift(z * fb, 16));
      comb_idx[c][k] = (p + 1 >= comb_len_tab[k]) ? 0 : p + 1;
      sum += y;
    end
    s = round_shift(sum, 2);
    for (int k = 0; k < 2; k++) begin
      p = ap_idx[c][k];
      y = ap_mem[c][k][p];
      v = clip24(s - round_shift(y, 1));
      ap_mem[c][k][p] = v;
      ap_idx[c][k] = (p + 1 >= ap_len_tab[k]) ? 0 : p + 1;
      s = clip24(y + round_shift(v, 1));
    end
    mixed = longint'(x) * (65536 - longint'(wet_share)) + s * longint'(wet_share);
    return clip24(round_shift(mixed, 16));
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      wet_share = MIX_WET_RST;
      room = ROOM_RST;
      damp = DAMPING_RST;
      pd_len = PREDELAY_RST;
      enabled = 1'b0;
      clear_reverb_state();
      expected_samples.delete();
      fail_count <= 0;
      results_seen <= 0;
      pending <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)
        apply_register(cfg_paddr[4:2], cfg_pwdata);
      if (out_pop && !out_empty) begin
        results_seen <= results_seen + 1;
        if (expected_samples.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %0d", out_sample_out);
          fail_count <= fail_count + 1;
        end else begin
          if (expected_samples[0] !== out_sample_out) begin
            if (fail_count < 10)
              $display("sample_out mismatch: expected %0d actual %0d",
                       expected_samples[0], out_sample_out);
            fail_count <= fail_count + 1;
          end
          void'(expected_samples.pop_front());
        end
      end
      if (in_push && !in_full)
        expected_samples.push_back(reverb_sample(int'(in_channel), in_sample_in));
      pending <= expected_samples.size();
    end
  end
endmodule

// ===== bench/schroeder_reverb_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Schroeder reverb unit testbench
// Drives directed and random sample requests on both channels through several
// register settings and handshake pressure levels; a checker compares results.
// ----------------------------------------------------------------------------
module schroeder_reverb_unit_tb
  import srv_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 4000000;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic               in_channel = 1'b0;
  logic signed [23:0] in_sample_in = '0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic signed [23:0] out_sample_out;
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [4:0]         cfg_paddr = '0;
  logic [31:0]        cfg_pwdata = '0;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;
  int                 fail_count;
  int                 pending;
  int                 results_seen;
  int                 idle_pct = 0;
  int                 stall_pct = 0;
  int                 requests_sent = 0;
  longint             cycle_count = 0;

  always #6 clk = ~clk;

  schroeder_reverb_unit dut (.*);

  schroeder_reverb_checker checker_i (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk) out_pop <= ($urandom_range(99) >= stall_pct);

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_sample(logic ch, logic signed [23:0] s);
    while ($urandom_range(99) < idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_channel <= ch;
    in_sample_in <= s;
    @(posedge clk);
    while (in_full) @(posedge clk);
    @(negedge clk);
    requests_sent++;
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic logic signed [23:0] random_sample();
    case ($urandom_range(5))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return 24'($urandom_range(2000) - 1000);
      default: return 24'($urandom());
    endcase
  endfunction

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_sample(1'b0, 24'sh7FFFFF);
    send_sample(1'b1, 24'sh800000);
    send_sample(1'b0, 24'sh000000);
    drain();
    write_reg(REG_REVERB_ON, 32'd1);
    write_reg(REG_PREDELAY, 32'd1);
    write_reg(REG_MIX_WET, 32'd65536);
    write_reg(REG_ROOM, 32'd62259);
    write_reg(REG_DAMPING, 32'd0);
    for (int i = 0; i < 16; i++)
      send_sample(i[0], i[1] ? 24'sh7FFFFF : 24'sh800000);
    drain();
    write_reg(REG_MIX_WET, 32'h1FFFF);
    write_reg(REG_ROOM, 32'd0);
    write_reg(REG_DAMPING, 32'hFFFF);
    write_reg(REG_PREDELAY, 32'd0);
    write_reg(REG_PREDELAY, 32'h1FFF);
    write_reg(REG_UNUSED, 32'd0);
    write_reg(REG_PREDELAY, 32'd3);
    for (int i = 0; i < 6; i++) send_sample(i[0], random_sample());
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 80; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 80; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      write_reg(REG_MIX_WET, (ph == 3) ? 32'd0 : $urandom_range(65536));
      write_reg(REG_ROOM, (ph == 5) ? 32'd13107 : $urandom_range(13107, 62259));
      write_reg(REG_DAMPING, (ph == 6) ? 32'd45875 : $urandom_range(45875));
      write_reg(REG_PREDELAY, (ph == 7) ? 32'd4800 : $urandom_range(1, 300));
      write_reg(REG_REVERB_ON, 32'(ph != 4));
      for (int i = 0; i < 178; i++) send_sample(1'($urandom_range(1)), random_sample());
      drain();
    end
    repeat (100) @(negedge clk);
    $display("Covered %0d sample requests, %0d results, over bypass and reverb settings.",
             requests_sent, results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// ===== schroeder_reverb_unit.f =====
sv/srv_pkg.sv
sv/srv_ram.sv
sv/srv_front.sv
sv/srv_back.sv
sv/srv_outq.sv
sv/schroeder_reverb_unit.sv
bench/schroeder_reverb_checker.sv
bench/schroeder_reverb_unit_tb.sv
